[hdl/mtt_pkg.sv]
// Shared types, constants and the markup decode for the markup text tokenizer.
package mtt_pkg;

	localparam int unsigned FIELD_W = 20;
	localparam int unsigned KIND_W = 5;
	localparam int unsigned SLOTS = 3;

	localparam longint unsigned MAX_TEXT_BYTES = 64'd1048576;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_WORD = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 5'd1;
	localparam logic [KIND_W-1:0] KIND_SPACE = 5'd2;
	localparam logic [KIND_W-1:0] KIND_END = 5'd18;

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] line;
	} token_t;

	// up to three tokens per input byte, emitted lowest set mask bit first
	typedef struct packed {
		logic [SLOTS-1:0]   mask;
		token_t [SLOTS-1:0] tok;
	} token_set_t;

	// markup kind 3..17, or KIND_WORD for anything that is not markup
	function automatic logic [KIND_W-1:0] markup_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			8'h23: k = 5'd3;   // #
			8'h2A: k = 5'd4;   // *
			8'h2F: k = 5'd5;   // /
			8'h5F: k = 5'd6;   // _
			8'h5B: k = 5'd7;   // [
			8'h5D: k = 5'd8;   // ]
			8'h28: k = 5'd9;   // (
			8'h29: k = 5'd10;  // )
			8'h2D: k = 5'd11;  // -
			8'h40: k = 5'd12;  // @
			8'h21: k = 5'd13;  // !
			8'h3B: k = 5'd14;  // ;
			8'h60: k = 5'd15;  // `
			8'h3A: k = 5'd16;  // :
			8'h2B: k = 5'd17;  // +
			default: k = KIND_WORD;
		endcase
		return k;
	endfunction

endpackage

[hdl/mtt_tok_gen.sv]
// Text state registers and the per-byte token set builder.
module mtt_tok_gen #(
	parameter longint unsigned MAX_TEXT_BYTES = mtt_pkg::MAX_TEXT_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [7:0]           text_byte,
	output mtt_pkg::token_set_t  tset
);

	localparam logic [mtt_pkg::FIELD_W-1:0] POS_CAP =
		(MAX_TEXT_BYTES - 64'd1 > 64'(mtt_pkg::FIELD_MAX)) ? mtt_pkg::FIELD_MAX :
		mtt_pkg::FIELD_W'(MAX_TEXT_BYTES - 64'd1);

	logic [mtt_pkg::FIELD_W-1:0] pos_q, ws_q, line_q;
	logic                        esc_q, started_q;

	logic [mtt_pkg::FIELD_W-1:0] pos_n, ws_n, line_n, pos_inc;
	logic                        esc_n, started_n;
	logic [mtt_pkg::KIND_W-1:0]  mk, main_kind;
	logic                        is_end, is_bs, is_nl, is_sp, is_mk, is_delim, special;
	logic                        lead, word;

	always_comb begin
		mk       = mtt_pkg::markup_kind(text_byte);
		is_end   = (text_byte == mtt_pkg::CH_END);
		is_bs    = (text_byte == mtt_pkg::CH_BACKSLASH);
		is_nl    = (text_byte == mtt_pkg::CH_NEWLINE);
		is_sp    = (text_byte == mtt_pkg::CH_SPACE);
		is_mk    = (mk != mtt_pkg::KIND_WORD);
		is_delim = is_nl || is_sp || is_mk;
		special  = is_end || is_bs || is_delim;
		lead     = !started_q;
		word     = special && (ws_q != pos_q);
		pos_inc  = (pos_q >= POS_CAP) ? POS_CAP : pos_q + 1'b1;

		if (is_end)
			main_kind = mtt_pkg::KIND_NEWLINE;
		else if (is_nl)
			main_kind = mtt_pkg::KIND_NEWLINE;
		else if (is_sp)
			main_kind = mtt_pkg::KIND_SPACE;
		else if (esc_q)
			main_kind = mtt_pkg::KIND_WORD;
		else
			main_kind = mk;

		// slot 0: opening newline or flushed word (never both)
		tset.mask[0] = lead || word;
		if (lead) begin
			tset.tok[0].kind   = mtt_pkg::KIND_NEWLINE;
			tset.tok[0].start  = '0;
			tset.tok[0].length = mtt_pkg::FIELD_W'(1);
			tset.tok[0].line   = '0;
		end else begin
			tset.tok[0].kind   = mtt_pkg::KIND_WORD;
			tset.tok[0].start  = ws_q;
			tset.tok[0].length = pos_q - ws_q;
			tset.tok[0].line   = line_q;
		end

		// slot 1: the delimiter itself, or the closing newline
		tset.mask[1]       = is_end || is_delim;
		tset.tok[1].kind   = main_kind;
		tset.tok[1].start  = is_end ? '0 : pos_q;
		tset.tok[1].length = is_end ? '0 : mtt_pkg::FIELD_W'(1);
		tset.tok[1].line   = is_end ? '0 : line_q;

		// slot 2: end marker
		tset.mask[2]       = is_end;
		tset.tok[2].kind   = mtt_pkg::KIND_END;
		tset.tok[2].start  = '0;
		tset.tok[2].length = '0;
		tset.tok[2].line   = '0;

		pos_n     = pos_inc;
		ws_n      = special ? pos_inc : ws_q;
		line_n    = (is_nl && line_q < mtt_pkg::FIELD_MAX) ? line_q + 1'b1 : line_q;
		started_n = 1'b1;
		if (is_bs)
			esc_n = 1'b1;
		else if (is_mk)
			esc_n = 1'b0;
		else
			esc_n = esc_q;
		if (is_end) begin
			pos_n     = '0;
			ws_n      = '0;
			line_n    = mtt_pkg::FIELD_W'(1);
			esc_n     = 1'b0;
			started_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ws_q      <= '0;
			line_q    <= mtt_pkg::FIELD_W'(1);
			esc_q     <= 1'b0;
			started_q <= 1'b0;
		end else if (adv) begin
			pos_q     <= pos_n;
			ws_q      <= ws_n;
			line_q    <= line_n;
			esc_q     <= esc_n;
			started_q <= started_n;
		end
	end

	// a fresh text has no pending word, so the opening newline and a word never collide
	a_lead_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (ws_q == pos_q))
		else $error("pending word before opening newline");

	// end of text puts the state back to its reset values
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_end) |=> (!esc_q && !started_q && pos_q == '0 &&
			line_q == mtt_pkg::FIELD_W'(1)))
		else $error("state not cleared after end of text");

	a_pos_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(ws_q <= pos_q) && (pos_q <= POS_CAP))
		else $error("word start or position out of range");

endmodule

[hdl/mtt_tok_queue.sv]
// Result register: holds one byte's token set and sends it out one token per transfer.
module mtt_tok_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         set_valid,
	input  mtt_pkg::token_set_t          tset,
	output logic                         load,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mtt_pkg::KIND_W-1:0]   token_kind,
	output logic [mtt_pkg::FIELD_W-1:0]  token_start,
	output logic [mtt_pkg::FIELD_W-1:0]  token_length,
	output logic [mtt_pkg::FIELD_W-1:0]  token_line,
	output logic                         last_of_run
);

	logic [mtt_pkg::SLOTS-1:0]   mask_q;
	mtt_pkg::token_t [mtt_pkg::SLOTS-1:0] tok_q;
	logic [mtt_pkg::SLOTS-1:0]   sel_oh;
	mtt_pkg::token_t             cur;
	logic                        single;

	always_comb begin
		sel_oh    = mask_q & (~mask_q + 1'b1);
		single    = (mask_q != '0) && ((mask_q & (mask_q - 1'b1)) == '0);
		out_valid = (mask_q != '0);
		if (mask_q[0])
			cur = tok_q[0];
		else if (mask_q[1])
			cur = tok_q[1];
		else
			cur = tok_q[2];
		// take a new set when empty or as the last pending token leaves
		load = set_valid && (!out_valid || (single && out_ready));
	end

	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.length;
	assign token_line   = cur.line;
	assign last_of_run  = single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= tset.mask;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			tok_q <= tset.tok;
	end

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_kind == mtt_pkg::KIND_END) |-> last_of_run)
		else $error("end marker not last token of its byte");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run && !load) |=> !out_valid)
		else $error("token left after last transfer of a run");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mask_q)))
		else $error("pending tokens changed while stalled");

endmodule

[hdl/markup_text_tokenizer.sv]
// Markup text tokenizer top level: input register, token builder and result register.
//
// Input channel in_valid/in_ready carries text_byte, one text byte per transfer;
// byte 0 ends a text. Output channel out_valid/out_ready carries one token per
// transfer: token_kind, token_start, token_length, token_line, last_of_run.
// last_of_run marks the final token caused by an input byte; ordinary bytes
// cause no token, but the first byte of a text brings the opening newline.
// The first token of a byte is presented from the result register, which loads
// the byte's token set from the input register. One byte per cycle is taken while
// each byte yields at most one token and out_ready stays high; a byte that yields
// more (up to three) holds the result register until the output port takes them all.
// The input register accepts a new byte while the result register still waits on
// the receiver, so one byte is buffered during an output stall; beyond that
// in_ready drops until the last pending token is taken.
// Reset clears the text state: position 0, line 1, no escape, and the next byte
// opens a text with a leading newline token. No clearing pass is needed.
module markup_text_tokenizer #(
	parameter longint unsigned MAX_TEXT_BYTES = mtt_pkg::MAX_TEXT_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   text_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mtt_pkg::KIND_W-1:0]   token_kind,
	output logic [mtt_pkg::FIELD_W-1:0]  token_start,
	output logic [mtt_pkg::FIELD_W-1:0]  token_length,
	output logic [mtt_pkg::FIELD_W-1:0]  token_line,
	output logic                         last_of_run
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                load;
	mtt_pkg::token_set_t tset;

	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= text_byte;
	end

	mtt_tok_gen #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (load),
		.text_byte (byte_s1),
		.tset      (tset)
	);

	mtt_tok_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.set_valid    (valid_s1),
		.tset         (tset),
		.load         (load),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

endmodule

[dv/testbench.sv]
// Self-checking testbench for the markup text tokenizer: directed and random texts.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned NUM_MARKUP = 15;
	// markup characters in kind order, first one maps to KIND_FIRST_MARKUP
	localparam logic [NUM_MARKUP*8-1:0] MARKUP_CHARS = "#*/_[]()-@!;`:+";
	localparam logic [mtt_pkg::KIND_W-1:0] KIND_FIRST_MARKUP = 5'd3;
	localparam longint unsigned POS_LIMIT =
		(mtt_pkg::MAX_TEXT_BYTES == 0) ? 0 : mtt_pkg::MAX_TEXT_BYTES - 1;
	localparam logic [mtt_pkg::FIELD_W-1:0] POS_CAP =
		(POS_LIMIT > mtt_pkg::FIELD_MAX) ? mtt_pkg::FIELD_MAX :
		mtt_pkg::FIELD_W'(POS_LIMIT);
	localparam int unsigned DRAIN_SLACK = 8;

	typedef struct packed {
		mtt_pkg::token_t tok;
		logic            last;
	} exp_token_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [7:0]                     text_byte = 8'h00;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [mtt_pkg::KIND_W-1:0]     token_kind;
	logic [mtt_pkg::FIELD_W-1:0]    token_start;
	logic [mtt_pkg::FIELD_W-1:0]    token_length;
	logic [mtt_pkg::FIELD_W-1:0]    token_line;
	logic                           last_of_run;

	// predicted text state
	logic [mtt_pkg::FIELD_W-1:0]    cur_pos;
	logic [mtt_pkg::FIELD_W-1:0]    word_begin;
	logic [mtt_pkg::FIELD_W-1:0]    cur_line;
	logic                           escaped;
	logic                           text_open;

	exp_token_t          pending_tokens[$];
	exp_token_t          want;
	int unsigned         idle_pct = 6;
	int unsigned         errors = 0;
	int unsigned         bytes_sent = 0;
	int unsigned         texts_done = 0;
	int unsigned         tokens_checked = 0;

	markup_text_tokenizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

	always #2 clk = ~clk;

	function automatic logic [mtt_pkg::KIND_W-1:0] decode_markup(input logic [7:0] c);
		for (int i = 0; i < NUM_MARKUP; i++) begin
			if (MARKUP_CHARS[(NUM_MARKUP-1-i)*8 +: 8] == c)
				return KIND_FIRST_MARKUP + mtt_pkg::KIND_W'(i);
		end
		return mtt_pkg::KIND_WORD;
	endfunction

	function automatic logic [mtt_pkg::FIELD_W-1:0] step_pos(
			input logic [mtt_pkg::FIELD_W-1:0] p);
		return (p >= POS_CAP) ? POS_CAP : p + 1'b1;
	endfunction

	task automatic reset_text_state();
		cur_pos = '0;
		word_begin = '0;
		cur_line = mtt_pkg::FIELD_W'(1);
		escaped = 1'b0;
		text_open = 1'b0;
	endtask

	task automatic emit(input logic [mtt_pkg::KIND_W-1:0] k,
			input logic [mtt_pkg::FIELD_W-1:0] s,
			input logic [mtt_pkg::FIELD_W-1:0] len,
			input logic [mtt_pkg::FIELD_W-1:0] ln);
		exp_token_t e;
		e.tok.kind = k;
		e.tok.start = s;
		e.tok.length = len;
		e.tok.line = ln;
		e.last = 1'b0;
		pending_tokens.push_back(e);
	endtask

	task automatic flush_word();
		if (word_begin != cur_pos)
			emit(mtt_pkg::KIND_WORD, word_begin, cur_pos - word_begin, cur_line);
		word_begin = cur_pos;
	endtask

	// expected tokens for one accepted text byte
	task automatic tokenize_byte(input logic [7:0] c);
		logic [mtt_pkg::KIND_W-1:0] mk;
		logic [mtt_pkg::KIND_W-1:0] kind;
		int unsigned                n_before;
		exp_token_t                 e;
		mk = decode_markup(c);
		n_before = pending_tokens.size();
		if (!text_open) begin
			emit(mtt_pkg::KIND_NEWLINE, '0, mtt_pkg::FIELD_W'(1), '0);
			text_open = 1'b1;
		end
		if (c == mtt_pkg::CH_END) begin
			flush_word();
			emit(mtt_pkg::KIND_NEWLINE, '0, '0, '0);
			emit(mtt_pkg::KIND_END, '0, '0, '0);
			reset_text_state();
			texts_done++;
		end else if (c == mtt_pkg::CH_BACKSLASH) begin
			flush_word();
			escaped = 1'b1;
			cur_pos = step_pos(cur_pos);
			word_begin = cur_pos;
		end else if (c == mtt_pkg::CH_NEWLINE || c == mtt_pkg::CH_SPACE ||
				mk != mtt_pkg::KIND_WORD) begin
			flush_word();
			if (c == mtt_pkg::CH_NEWLINE) begin
				kind = mtt_pkg::KIND_NEWLINE;
			end else if (c == mtt_pkg::CH_SPACE) begin
				kind = mtt_pkg::KIND_SPACE;
			end else if (escaped) begin
				kind = mtt_pkg::KIND_WORD;
				escaped = 1'b0;
			end else begin
				kind = mk;
			end
			emit(kind, cur_pos, mtt_pkg::FIELD_W'(1), cur_line);
			if (c == mtt_pkg::CH_NEWLINE && cur_line != mtt_pkg::FIELD_MAX)
				cur_line = cur_line + 1'b1;
			cur_pos = step_pos(cur_pos);
			word_begin = cur_pos;
		end else begin
			cur_pos = step_pos(cur_pos);
		end
		if (pending_tokens.size() > n_before) begin
			e = pending_tokens.pop_back();
			e.last = 1'b1;
			pending_tokens.push_back(e);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!in_ready);
		tokenize_byte(b);
		bytes_sent++;
	endtask

	task automatic wait_all_tokens();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return 8'h61 + 8'($urandom_range(25));
		else if (r < 63)
			return MARKUP_CHARS[$urandom_range(NUM_MARKUP-1)*8 +: 8];
		else if (r < 73)
			return mtt_pkg::CH_SPACE;
		else if (r < 80)
			return mtt_pkg::CH_NEWLINE;
		else if (r < 87)
			return mtt_pkg::CH_BACKSLASH;
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic check_field(input string name,
			input logic [mtt_pkg::FIELD_W-1:0] exp_val,
			input logic [mtt_pkg::FIELD_W-1:0] act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			errors++;
		end
	endtask

	// receiver: random stalls on out_ready
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token kind %0d start %0d length %0d line %0d",
					$time, token_kind, token_start, token_length, token_line);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_kind", mtt_pkg::FIELD_W'(want.tok.kind),
					mtt_pkg::FIELD_W'(token_kind));
				check_field("token_start", want.tok.start, token_start);
				check_field("token_length", want.tok.length, token_length);
				check_field("token_line", want.tok.line, token_line);
				check_field("last_of_run", mtt_pkg::FIELD_W'(want.last),
					mtt_pkg::FIELD_W'(last_of_run));
				tokens_checked++;
			end
		end
	end

	task automatic test_empty_text();
		send_byte(mtt_pkg::CH_END);
	endtask

	// every markup kind, highest byte value as a word flushed ahead of the first one
	task automatic test_markup_kinds();
		send_byte(8'hFF);
		for (int i = 0; i < NUM_MARKUP; i++)
			send_byte(MARKUP_CHARS[(NUM_MARKUP-1-i)*8 +: 8]);
		send_byte(mtt_pkg::CH_END);
	endtask

	// double backslash, escaped markup, flag kept across space and newline
	task automatic test_escapes();
		send_byte(mtt_pkg::CH_BACKSLASH);
		send_byte(mtt_pkg::CH_BACKSLASH);
		send_byte("*");
		send_byte("a");
		send_byte(mtt_pkg::CH_BACKSLASH);
		send_byte(mtt_pkg::CH_SPACE);
		send_byte(mtt_pkg::CH_NEWLINE);
		send_byte("(");
		send_byte(mtt_pkg::CH_END);
	endtask

	task automatic test_random_texts(input int unsigned n_bytes);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(120, 30) : $urandom_range(24, 1);
			for (int unsigned i = 0; i < len; i++)
				send_byte(pick_text_byte());
			send_byte(mtt_pkg::CH_END);
			sent += len + 1;
			if ($urandom_range(19) == 0)
				wait_all_tokens();
		end
	endtask

	task automatic test_no_idle_burst();
		idle_pct = 0;
		test_random_texts(100);
		idle_pct = 6;
	endtask

	// sender holds off mid-text until the block has drained
	task automatic test_drain_pause();
		send_byte("a");
		send_byte("b");
		send_byte("#");
		wait_all_tokens();
		send_byte("c");
		wait_all_tokens();
		send_byte(mtt_pkg::CH_NEWLINE);
		send_byte(mtt_pkg::CH_END);
	endtask

	initial begin
		reset_text_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_text();
		test_markup_kinds();
		test_escapes();
		test_drain_pause();
		test_random_texts(300);
		test_no_idle_burst();
		wait_all_tokens();
		repeat (DRAIN_SLACK) @(posedge clk);
		$display("Sent %0d bytes in %0d texts, checked %0d tokens", bytes_sent, texts_done,
			tokens_checked);
		$display("Covered framing, every markup kind, escapes, stalls and a drain pause");
		if (errors == 0 && pending_tokens.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d tokens outstanding", pending_tokens.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/mtt_pkg.sv
hdl/mtt_tok_gen.sv
hdl/mtt_tok_queue.sv
hdl/markup_text_tokenizer.sv
dv/testbench.sv
